@@ sv/srv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// srv_pkg: shared types and constants of the sparse row variance block
// Field widths, opcodes, the row memory word and the divider sizes.
// ============================================================================
package srv_pkg;

    localparam int OPCODE_W = 2;
    localparam int ROW_W    = 10;
    localparam int VALUE_W  = 32;
    localparam int COLS_W   = 24;
    localparam int SUM_W    = 64;
    localparam int VAR_W    = 48;

    // Opcodes of a request.
    localparam logic [OPCODE_W-1:0] OP_SET_MEAN = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ACCUM    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ     = 2'd2;

    // Readout numerator: rest * mean^2 + sum stays below 2^87.
    localparam int PROD_W = COLS_W + VALUE_W;   // 24 x 32 partial products
    localparam int NUM_W  = PROD_W + VALUE_W;   // 88 bits

    // Serial divider: high part below the divisor, then 48 bits shifted in.
    localparam int DIV_W  = COLS_W;
    localparam int QUO_W  = VAR_W;
    localparam int CNT_W  = $clog2(QUO_W);

    // One row of state as it sits in the row memory.
    typedef struct packed {
        logic [VALUE_W-1:0] mean;
        logic [SUM_W-1:0]   sum;
        logic [COLS_W-1:0]  count;
        logic               flag;
    } t_row_word;

endpackage : srv_pkg
`default_nettype wire

@@ sv/srv_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// srv_div: restoring radix-2 divider
// Divides {i_high, i_low} by i_divisor with i_high below i_divisor, one
// quotient bit per cycle, and pulses o_done with the quotient.
// ============================================================================
module srv_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [srv_pkg::DIV_W-1:0]  i_high,
    input  wire logic [srv_pkg::QUO_W-1:0]  i_low,
    input  wire logic [srv_pkg::DIV_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic      [srv_pkg::QUO_W-1:0]  o_quotient
);
    import srv_pkg::*;

    logic             r_active;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_divisor;
    logic [QUO_W-1:0] r_shift;

    logic [DIV_W:0]   w_trial;
    logic             w_fit;
    logic [DIV_W-1:0] n_rem;

    // The dividend bits leave the top of r_shift while quotient bits enter below.
    always_comb begin
        w_trial = {r_rem, r_shift[QUO_W-1]};
        w_fit   = (w_trial >= {1'b0, r_divisor});
        n_rem   = w_fit ? DIV_W'(w_trial - {1'b0, r_divisor}) : w_trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            // The last quotient bit is taken in the step where the count is zero.
            r_done <= r_active && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= CNT_W'(QUO_W - 1);
            end else if (r_active) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_high;
            r_shift   <= i_low;
            r_divisor <= i_divisor;
        end else if (r_active) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[QUO_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_shift;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_rem < r_divisor))
        else $error("divider remainder reached the divisor");

    a_done_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_active))
        else $error("divider done without a running division");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !i_start)
        else $error("divider restarted while busy");
`endif
endmodule : srv_div
`default_nettype wire

@@ sv/sparse_row_variance.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sparse_row_variance: per-row sample variance of a sparse matrix
// Keeps a mean, a sum of squared deviations, an entry count and an overflow
// flag for each row in one memory, and returns row variances on request.
// ============================================================================
//
//  Channel   Signals                                     Handshake
//  --------  ------------------------------------------  --------------------
//  request   i_opcode, i_row_index, i_sample_value       start & !busy
//  result    o_result_row, o_variance, o_saturated       o_result_valid pulse
//  config    i_cfg_wdata (column count)                  i_cfg_we
//
//  A set-mean request is written to the row memory at the edge that accepts
//  it, so busy stays low and the next request can follow in the next cycle.
//  An accumulate request passes through a memory read, deviation, square,
//  then the read-modify-write of the row.
//  A read request passes through the deviate, square, scale, sum and check
//  states, then waits for the 48 one-bit steps of the serial divider; a read
//  whose quotient saturates returns from the check state without a division.
//  After reset the block sweeps the row memory to zero, one row per cycle, over
//  all ROW_COUNT rows with busy high; column count writes are taken meanwhile.
//  Results are shown for one cycle; the receiver cannot stall them.
//
module sparse_row_variance #(
    parameter int ROW_COUNT = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [srv_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire logic [srv_pkg::ROW_W-1:0]     i_row_index,
    input  wire logic signed [srv_pkg::VALUE_W-1:0] i_sample_value,
    input  wire logic                          i_cfg_we,
    input  wire logic [srv_pkg::COLS_W-1:0]    i_cfg_wdata,
    output logic                               o_result_valid,
    output logic      [srv_pkg::ROW_W-1:0]     o_result_row,
    output logic      [srv_pkg::VAR_W-1:0]     o_variance,
    output logic                               o_saturated
);
    import srv_pkg::*;

    // Address width of the row memory, and a row index wide enough to compare
    // against any row count in range.
    localparam int ADDR_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int ROWX_W  = 17;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_DEVIATE = 8'b0000_0010,
        ST_SQUARE  = 8'b0000_0100,
        ST_ACCUM   = 8'b0000_1000,
        ST_SCALE   = 8'b0001_0000,
        ST_SUM     = 8'b0010_0000,
        ST_CHECK   = 8'b0100_0000,
        ST_DIVIDE  = 8'b1000_0000
    } t_state;

    // ---------------------------------------------------------------- state
    t_state               r_state;
    t_state               n_state;
    logic                 r_clr_active;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [COLS_W-1:0]    r_col_count;

    // Request held for the duration of its work.
    logic [OPCODE_W-1:0]  r_op;
    logic [ROW_W-1:0]     r_row;
    logic [ADDR_W-1:0]    r_addr;
    logic [VALUE_W-1:0]   r_value;

    // Row memory and its registered read data.
    t_row_word            r_mem [ROW_COUNT];
    t_row_word            r_rd_data;

    // Datapath registers.
    logic [VALUE_W:0]     r_mag;
    logic [SUM_W-1:0]     r_prod;
    logic [COLS_W-1:0]    r_rest;
    logic [COLS_W-1:0]    r_divisor;
    logic [PROD_W-1:0]    r_ph;
    logic [PROD_W-1:0]    r_pl;
    logic [NUM_W-1:0]     r_num;
    logic                 r_sat;

    logic                 r_out_valid;
    logic [ROW_W-1:0]     r_out_row;
    logic [VAR_W-1:0]     r_out_var;
    logic                 r_out_sat;

    // ----------------------------------------------------------- decoding
    logic [ROWX_W-1:0]    w_row_ext;
    logic [ADDR_W-1:0]    w_req_addr;
    logic                 w_row_ok;
    logic                 w_accept;
    logic                 w_rd_en;

    assign w_row_ext  = ROWX_W'(i_row_index);
    assign w_req_addr = w_row_ext[ADDR_W-1:0];
    assign w_row_ok   = (w_row_ext < ROWX_W'(ROW_COUNT));
    assign busy       = r_clr_active || (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    // Accumulate and read requests fetch their row at the accepting edge.
    assign w_rd_en    = w_accept && w_row_ok &&
                        ((i_opcode == OP_ACCUM) || (i_opcode == OP_READ));

    // -------------------------------------------------------- arithmetic
    logic [COLS_W-1:0]    w_cols;
    logic [VALUE_W:0]     w_dev;
    logic [VALUE_W:0]     w_dev_mag;
    logic [VALUE_W:0]     w_mean_ext;
    logic [VALUE_W:0]     w_mean_mag;
    logic [SUM_W-1:0]     w_sq;
    logic [SUM_W:0]       w_sum_ext;
    logic                 w_cnt_full;
    t_row_word            w_acc_word;
    logic [DIV_W-1:0]     w_num_high;
    logic                 w_quo_over;

    always_comb begin
        // Fewer than two columns are taken as two.
        w_cols     = (r_col_count < COLS_W'(2)) ? COLS_W'(2) : r_col_count;
        w_mean_ext = {r_rd_data.mean[VALUE_W-1], r_rd_data.mean};
        w_dev      = {r_value[VALUE_W-1], r_value} - w_mean_ext;
        w_dev_mag  = w_dev[VALUE_W] ? ((VALUE_W+1)'(0) - w_dev) : w_dev;
        w_mean_mag = w_mean_ext[VALUE_W] ? ((VALUE_W+1)'(0) - w_mean_ext) : w_mean_ext;

        // A deviation of magnitude 2^32 would square past the sum range.
        w_sq       = r_mag[VALUE_W] ? '1 : r_prod;
        w_sum_ext  = {1'b0, r_rd_data.sum} + {1'b0, w_sq};
        w_cnt_full = (r_rd_data.count == '1);

        w_acc_word.mean  = r_rd_data.mean;
        w_acc_word.sum   = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
        w_acc_word.count = w_cnt_full ? r_rd_data.count : r_rd_data.count + COLS_W'(1);
        w_acc_word.flag  = r_rd_data.flag | r_mag[VALUE_W] | w_sum_ext[SUM_W] | w_cnt_full;

        // The quotient fits in 48 bits only if the part from bit 64 upward is below
        // the divisor.
        w_num_high = r_num[NUM_W-1 -: DIV_W];
        w_quo_over = (w_num_high >= r_divisor);
    end

    // ------------------------------------------------------ row memory
    logic                 w_mem_we;
    logic [ADDR_W-1:0]    w_mem_addr;
    t_row_word            w_mem_wdata;

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_addr  = r_clr_addr;
        w_mem_wdata = '0;
        priority if (r_clr_active) begin
            w_mem_we = 1'b1;
        end else if (w_accept && w_row_ok && (i_opcode == OP_SET_MEAN)) begin
            // A new mean clears the row's sum, count and flag.
            w_mem_we         = 1'b1;
            w_mem_addr       = w_req_addr;
            w_mem_wdata.mean = i_sample_value;
        end else if (r_state == ST_ACCUM) begin
            w_mem_we    = 1'b1;
            w_mem_addr  = r_addr;
            w_mem_wdata = w_acc_word;
        end else begin
            w_mem_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_req_addr];
        end
    end

    // -------------------------------------------------------- divider
    logic                 w_div_start;
    logic                 w_div_done;
    logic [QUO_W-1:0]     w_quotient;

    assign w_div_start = (r_state == ST_CHECK) && !w_quo_over;

    srv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_high     (w_num_high),
        .i_low      (r_num[NUM_W-DIV_W-1 -: QUO_W]),
        .i_divisor  (r_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // ---------------------------------------------------------- control
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_rd_en) begin
                            n_state = ST_DEVIATE;
                        end
            ST_DEVIATE: n_state = ST_SQUARE;
            ST_SQUARE:  n_state = (r_op == OP_ACCUM) ? ST_ACCUM : ST_SCALE;
            ST_ACCUM:   n_state = ST_IDLE;
            ST_SCALE:   n_state = ST_SUM;
            ST_SUM:     n_state = ST_CHECK;
            ST_CHECK:   n_state = w_quo_over ? ST_IDLE : ST_DIVIDE;
            ST_DIVIDE:  if (w_div_done) begin
                            n_state = ST_IDLE;
                        end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_col_count  <= COLS_W'(2);
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= ((r_state == ST_CHECK) && w_quo_over) ||
                           ((r_state == ST_DIVIDE) && w_div_done);
            if (i_cfg_we) begin
                r_col_count <= i_cfg_wdata;
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(ROW_COUNT - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_opcode;
            r_row   <= i_row_index;
            r_addr  <= w_req_addr;
            r_value <= i_sample_value;
        end

        // The shared squarer takes the entry deviation for an accumulate and
        // the row mean for a read.
        if (r_state == ST_DEVIATE) begin
            r_mag     <= (r_op == OP_ACCUM) ? w_dev_mag : w_mean_mag;
            r_divisor <= w_cols - COLS_W'(1);
            r_rest    <= (r_rd_data.count > w_cols) ? '0 : w_cols - r_rd_data.count;
        end

        if (r_state == ST_SQUARE) begin
            r_prod <= SUM_W'(r_mag[VALUE_W-1:0]) * SUM_W'(r_mag[VALUE_W-1:0]);
        end

        // Implicit columns times mean squared, in two 24 x 32 halves.
        if (r_state == ST_SCALE) begin
            r_ph <= PROD_W'(r_rest) * PROD_W'(r_prod[SUM_W-1 -: VALUE_W]);
            r_pl <= PROD_W'(r_rest) * PROD_W'(r_prod[VALUE_W-1:0]);
        end

        if (r_state == ST_SUM) begin
            r_num <= {r_ph, VALUE_W'(0)} + NUM_W'(r_pl) + NUM_W'(r_rd_data.sum);
            r_sat <= r_rd_data.flag;
        end

        if ((r_state == ST_CHECK) && w_quo_over) begin
            r_out_row <= r_row;
            r_out_var <= '1;
            r_out_sat <= 1'b1;
        end else if ((r_state == ST_DIVIDE) && w_div_done) begin
            r_out_row <= r_row;
            r_out_var <= w_quotient;
            r_out_sat <= r_sat;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_row   = r_out_row;
    assign o_variance     = r_out_var;
    assign o_saturated    = r_out_sat;

`ifndef SYNTHESIS
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    a_div_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_row_ok && (i_opcode == OP_READ)) |=> (r_state == ST_DEVIATE))
        else $error("accepted read request did not start");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (r_state == ST_IDLE))
        else $error("request in progress during the clearing sweep");
`endif
endmodule : sparse_row_variance
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench of the sparse row variance block
// Drives set-mean, accumulate and read requests, predicts each row variance
// from a private copy of the row statistics and checks every result pulse.
// ============================================================================
module tb;
    import srv_pkg::*;

    localparam int ROWS          = 1024;
    localparam int DRAIN_LIMIT   = 5000;   // cycles allowed for pending results
    localparam int SETTLE_CYCLES = 64;     // longer than a full read takes

    // The block has no name for the unused opcode; requests with it are ignored.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [VAR_W-1:0] variance;
        logic             saturated;
    } t_row_variance;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       start          = 1'b0;
    logic                       busy;
    logic [OPCODE_W-1:0]        i_opcode       = '0;
    logic [ROW_W-1:0]           i_row_index    = '0;
    logic signed [VALUE_W-1:0]  i_sample_value = '0;
    logic                       i_cfg_we       = 1'b0;
    logic [COLS_W-1:0]          i_cfg_wdata    = '0;
    logic                       o_result_valid;
    logic [ROW_W-1:0]           o_result_row;
    logic [VAR_W-1:0]           o_variance;
    logic                       o_saturated;

    // Private copy of the row statistics and of the column count register.
    logic [VALUE_W-1:0] row_mean      [ROWS];
    logic [SUM_W-1:0]   row_sq_sum    [ROWS];
    logic [COLS_W-1:0]  row_entries   [ROWS];
    logic               row_overflow  [ROWS];
    logic [COLS_W-1:0]  column_count;

    // Variances predicted for accepted read requests, oldest first.
    t_row_variance pending_variances[$];

    int sender_idle_pct = 0;
    int failures        = 0;

    sparse_row_variance #(
        .ROW_COUNT(ROWS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_row_index    (i_row_index),
        .i_sample_value (i_sample_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result_row   (o_result_row),
        .o_variance     (o_variance),
        .o_saturated    (o_saturated)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Sample variance over the configured columns, where the columns without
    // an explicit entry count as zeros: (sum + rest * mean^2) / (n - 1).
    // The numerator is exact; a quotient that does not fit in 64 bits, and so
    // not in Q32.16 either, saturates.
    function automatic t_row_variance predict_row_variance(input logic [ROW_W-1:0] row);
        logic [COLS_W:0]    cols_eff;
        logic [63:0]        divisor;
        logic [63:0]        rest;
        logic [VALUE_W-1:0] mean_mag;
        logic [63:0]        mean_sq;
        logic [127:0]       numerator;
        logic [127:0]       quotient;
        t_row_variance      res;
        cols_eff  = (column_count < 24'd2) ? 25'd2 : {1'b0, column_count};
        divisor   = cols_eff - 64'd1;
        // More explicit entries than columns leaves no implicit zeros.
        rest      = ({1'b0, row_entries[row]} > cols_eff) ? 64'd0 : cols_eff - row_entries[row];
        mean_mag  = row_mean[row][VALUE_W-1] ? (~row_mean[row] + 32'd1) : row_mean[row];
        mean_sq   = mean_mag * mean_mag;
        numerator = rest * mean_sq + row_sq_sum[row];
        res.row       = row;
        res.saturated = row_overflow[row];
        if ((numerator >> 64) >= divisor) begin
            res.variance  = '1;
            res.saturated = 1'b1;
        end else begin
            quotient     = numerator / divisor;
            res.variance = quotient[63:16];
        end
        return res;
    endfunction

    // Applies one accepted request to the private row statistics.
    task automatic apply_request(input logic [OPCODE_W-1:0] op,
                                 input logic [ROW_W-1:0]    row,
                                 input logic [VALUE_W-1:0]  value);
        logic [32:0] deviation;
        logic [32:0] dev_mag;
        logic [63:0] square;
        logic [64:0] total;
        case (op)
            OP_SET_MEAN: begin
                row_mean[row]     = value;
                row_sq_sum[row]   = '0;
                row_entries[row]  = '0;
                row_overflow[row] = 1'b0;
            end
            OP_ACCUM: begin
                // The deviation needs 33 bits; its square is exact below 2^32.
                deviation = {value[31], value} - {row_mean[row][31], row_mean[row]};
                dev_mag   = deviation[32] ? (~deviation + 33'd1) : deviation;
                if (dev_mag[32]) begin
                    square            = '1;
                    row_overflow[row] = 1'b1;
                end else begin
                    square = dev_mag[31:0] * dev_mag[31:0];
                end
                total = {1'b0, row_sq_sum[row]} + {1'b0, square};
                if (total[64]) begin
                    row_sq_sum[row]   = '1;
                    row_overflow[row] = 1'b1;
                end else begin
                    row_sq_sum[row] = total[63:0];
                end
                if (row_entries[row] == '1) begin
                    row_overflow[row] = 1'b1;
                end else begin
                    row_entries[row] = row_entries[row] + 24'd1;
                end
            end
            OP_READ: begin
                pending_variances.push_back(predict_row_variance(row));
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result checking: every result pulse is matched against the oldest
    // predicted variance. Outputs are sampled at the rising edge, before the
    // block updates them.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_row_variance want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_variances.size() == 0) begin
                $error("result for row %0d with no read request waiting", o_result_row);
                failures++;
            end else begin
                want = pending_variances.pop_front();
                if (o_result_row !== want.row) begin
                    $error("result_row mismatch: expected %0d, actual %0d",
                           want.row, o_result_row);
                    failures++;
                end
                if (o_variance !== want.variance) begin
                    $error("variance mismatch: expected 0x%012h, actual 0x%012h",
                           want.variance, o_variance);
                    failures++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated mismatch: expected %0b, actual %0b",
                           want.saturated, o_saturated);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------------

    // Sends one request and returns at the edge that accepts it, with start
    // still high. Idle cycles are drawn before the request is raised, so they
    // fall both inside and beyond the busy time of the previous request.
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic [ROW_W-1:0]    row,
                                input logic [VALUE_W-1:0]  value);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_opcode       <= op;
        i_row_index    <= row;
        i_sample_value <= value;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        apply_request(op, row, value);
    endtask

    // Lowers start and waits until every predicted variance has come back,
    // then lets a full read time pass so that an accumulate still in flight
    // has finished too.
    task automatic wait_for_results();
        int waited;
        start  <= 1'b0;
        waited = 0;
        while (pending_variances.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_variances.size() != 0) begin
            $error("%0d expected results never arrived", pending_variances.size());
            failures += pending_variances.size();
            pending_variances.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The column count is only changed while the block is idle.
    task automatic write_column_count(input logic [COLS_W-1:0] cols);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cols;
        @(posedge i_clk);
        column_count = cols;
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Rows never written read as zero after the clearing sweep.
    task automatic test_cleared_rows();
        send_request(OP_READ, 10'd0, 32'h0000_0000);
        send_request(OP_READ, 10'd1023, 32'hFFFF_FFFF);
    endtask

    // Column counts below two act as two; the largest count leaves a variance
    // dominated by the implicit zeros.
    task automatic test_column_count_bounds();
        logic [COLS_W-1:0] bounds [3];
        bounds = '{24'd0, 24'd1, 24'hFF_FFFF};
        foreach (bounds[i]) begin
            write_column_count(bounds[i]);
            send_request(OP_SET_MEAN, 10'd3, 32'h0001_8000);
            send_request(OP_ACCUM, 10'd3, 32'hFFFF_0000);
            send_request(OP_READ, 10'd3, 32'h0000_0000);
        end
    endtask

    // Extreme means and values: the largest deviation, a saturating sum, a
    // quotient too large for Q32.16, more entries than columns and the
    // ignored opcode.
    task automatic test_value_extremes();
        write_column_count(24'd2);
        send_request(OP_SET_MEAN, 10'd1023, 32'h8000_0000);
        send_request(OP_ACCUM, 10'd1023, 32'h7FFF_FFFF);
        send_request(OP_READ, 10'd1023, 32'h0000_0000);

        send_request(OP_SET_MEAN, 10'd0, 32'h7FFF_FFFF);
        send_request(OP_ACCUM, 10'd0, 32'h8000_0000);
        send_request(OP_ACCUM, 10'd0, 32'h8000_0000);
        send_request(OP_READ, 10'd0, 32'hFFFF_FFFF);

        send_request(OP_SET_MEAN, 10'd7, 32'h0001_0000);
        repeat (3) send_request(OP_ACCUM, 10'd7, 32'h0003_0000);
        send_request(OP_READ, 10'd7, 32'h0000_0000);
        send_request(OP_UNUSED, 10'd7, 32'h5555_AAAA);
        send_request(OP_READ, 10'd7, 32'hAAAA_5555);
    endtask

    // Mostly whole row sequences (mean, a few entries, readout) with random
    // content, mixed with single random requests that break the sequences.
    task automatic test_random_traffic(input int idle_pct, input int item_target,
                                       input logic [COLS_W-1:0] cols);
        int                 sent;
        int                 entries;
        logic [ROW_W-1:0]   row;
        logic [VALUE_W-1:0] mean;
        logic [VALUE_W-1:0] value;
        logic [OPCODE_W-1:0] op;
        write_column_count(cols);
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < item_target) begin
            row = ROW_W'($urandom_range(ROWS - 1));
            if ($urandom_range(99) < 70) begin
                case ($urandom_range(3))
                    0: mean = $urandom;
                    1: mean = 32'($urandom_range(32'h001F_FFFF)) - 32'h0010_0000;
                    2: mean = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: mean = '0;
                endcase
                send_request(OP_SET_MEAN, row, mean);
                entries = $urandom_range(8);
                repeat (entries) begin
                    if ($urandom_range(3) == 0) begin
                        value = $urandom;
                    end else begin
                        value = mean + 32'($urandom_range(32'h0003_FFFF)) - 32'h0002_0000;
                    end
                    send_request(OP_ACCUM, row, value);
                end
                send_request(OP_READ, row, $urandom);
                sent += entries + 2;
                // Now and then the sender holds off until the block is empty.
                if ($urandom_range(99) < 4) begin
                    wait_for_results();
                end
            end else begin
                op = OPCODE_W'($urandom_range(3));
                send_request(op, row, $urandom);
                if (op != OP_UNUSED) begin
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int r = 0; r < ROWS; r++) begin
            row_mean[r]     = '0;
            row_sq_sum[r]   = '0;
            row_entries[r]  = '0;
            row_overflow[r] = 1'b0;
        end
        column_count = 24'd2;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 25;
        test_cleared_rows();
        test_column_count_bounds();
        test_value_extremes();

        test_random_traffic(25, 270, 24'($urandom_range(2, 16)));
        test_random_traffic(76, 270, 24'($urandom_range(2, 24'hFF_FFFF)));
        test_random_traffic(0, 270, 24'd5);

        wait_for_results();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // A correct run needs well under a millisecond; this only catches hangs.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule : tb

@@ filelist.f @@
sv/srv_pkg.sv
sv/srv_div.sv
sv/sparse_row_variance.sv
verif/tb.sv
